// ===== src/pkvt_pkg.sv =====
// Package for the per-key vote mode tracker: sizes, command and state types.
// Used by every module under src; depends on nothing.

package pkvt_pkg;

	// Table sizes. Keys and relations are powers of two, so wrapping an
	// out-of-range id is a plain truncation to the low bits.
	localparam int NUM_KEYS      = 64;
	localparam int NUM_RELATIONS = 64;
	localparam int COUNT_BITS    = 8;

	// Fixed port widths.
	localparam int FUNC_W   = 1;
	localparam int KEY_IN_W = 6;
	localparam int REL_IN_W = 6;
	localparam int LEADER_W = 6;
	localparam int BEST_W   = 8;

	localparam int KEY_W      = $clog2(NUM_KEYS);
	localparam int REL_W      = $clog2(NUM_RELATIONS);
	localparam int ADDR_W     = KEY_W + REL_W;
	localparam int LEN_W      = $clog2(NUM_RELATIONS + 1);
	localparam int VOTE_DEPTH = NUM_KEYS * NUM_RELATIONS;

	// Command queue between front and back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [FUNC_W-1:0] {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
		logic [REL_W-1:0] rel;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_push_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	// Per-key summary word: best count and length of the tied-leader list.
	typedef struct packed {
		logic [COUNT_BITS-1:0] best;
		logic [LEN_W-1:0]      len;
	} key_info_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ADD,
		ST_QINFO,
		ST_QEMIT
	} back_state_t;

endpackage

// ===== src/pkvt_front.sv =====
// Front end of the vote tracker: takes input transfers, decodes and wraps ids.
// Depends on pkvt_pkg; feeds pkvt_queue.

module pkvt_front (
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [pkvt_pkg::FUNC_W-1:0]   func,
	input  logic [pkvt_pkg::KEY_IN_W-1:0] key,
	input  logic [pkvt_pkg::REL_IN_W-1:0] relation,
	input  logic                          clearing,
	input  logic                          q_full,
	output pkvt_pkg::q_push_t             push
);

	pkvt_pkg::op_t op;

	always_comb begin
		unique case (func)
			1'b0:    op = pkvt_pkg::OP_ADD;
			default: op = pkvt_pkg::OP_QUERY;
		endcase
	end

	// Nothing is taken while the tables are being swept after reset.
	assign item_ready    = !q_full && !clearing;
	assign push.valid    = item_valid && item_ready;
	assign push.cmd.op   = op;
	assign push.cmd.key  = key[pkvt_pkg::KEY_W-1:0];
	assign push.cmd.rel  = relation[pkvt_pkg::REL_W-1:0];

endmodule

// ===== src/pkvt_queue.sv =====
// Short command queue between the front and back of the vote tracker.
// Depends on pkvt_pkg.

module pkvt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  pkvt_pkg::q_push_t push,
	output logic              full,
	output pkvt_pkg::q_head_t head,
	input  logic              pop
);

	pkvt_pkg::cmd_t                entry_q [pkvt_pkg::Q_DEPTH];
	logic [pkvt_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [pkvt_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [pkvt_pkg::Q_CNT_W-1:0]  cnt_q;
	logic                          do_push;
	logic                          do_pop;

	function automatic logic [pkvt_pkg::Q_PTR_W-1:0] ptr_inc(
		input logic [pkvt_pkg::Q_PTR_W-1:0] p
	);
		if (p == pkvt_pkg::Q_PTR_W'(pkvt_pkg::Q_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	assign full       = (cnt_q == pkvt_pkg::Q_CNT_W'(pkvt_pkg::Q_DEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= push.cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== src/pkvt_back.sv =====
// Back end of the vote tracker: count, summary and leader memories, the
// sequencer that runs adds and queries, and the result register.
// Depends on pkvt_pkg; takes commands from pkvt_queue.

module pkvt_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pkvt_pkg::q_head_t             head,
	output logic                          pop,
	output logic                          clearing,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          is_new,
	output logic [pkvt_pkg::LEADER_W-1:0] leader,
	output logic                          leader_valid,
	output logic [pkvt_pkg::BEST_W-1:0]   best_count,
	output logic                          last
);

	pkvt_pkg::back_state_t state_q, state_d;
	pkvt_pkg::cmd_t        cmd_q;
	logic                  clr_q;
	logic [pkvt_pkg::ADDR_W-1:0] clr_addr_q;

	// Memories
	logic [pkvt_pkg::COUNT_BITS-1:0] vote_mem   [pkvt_pkg::VOTE_DEPTH];
	pkvt_pkg::key_info_t             info_mem   [pkvt_pkg::NUM_KEYS];
	logic [pkvt_pkg::REL_W-1:0]      leader_mem [pkvt_pkg::VOTE_DEPTH];

	logic [pkvt_pkg::COUNT_BITS-1:0] vote_rd_q;
	pkvt_pkg::key_info_t             info_rd_q;
	logic [pkvt_pkg::REL_W-1:0]      leader_rd_q;

	logic                            vote_re, vote_we;
	logic [pkvt_pkg::ADDR_W-1:0]     vote_raddr, vote_waddr;
	logic [pkvt_pkg::COUNT_BITS-1:0] vote_wdata;
	logic                            info_re, info_we;
	logic [pkvt_pkg::KEY_W-1:0]      info_raddr, info_waddr;
	pkvt_pkg::key_info_t             info_wdata;
	logic                            leader_re, leader_we;
	logic [pkvt_pkg::ADDR_W-1:0]     leader_raddr, leader_waddr;
	logic [pkvt_pkg::REL_W-1:0]      leader_wdata;

	logic [pkvt_pkg::REL_W-1:0]      idx_q, idx_d;
	logic                            idx_load;

	// Result register
	logic                            out_valid_q;
	logic                            out_is_new_q, out_leader_valid_q, out_last_q;
	logic [pkvt_pkg::REL_W-1:0]      out_leader_q;
	logic [pkvt_pkg::COUNT_BITS-1:0] out_best_q;
	logic                            out_free, out_load;
	logic                            out_is_new_d, out_leader_valid_d, out_last_d;
	logic [pkvt_pkg::REL_W-1:0]      out_leader_d;
	logic [pkvt_pkg::COUNT_BITS-1:0] out_best_d;

	// Add datapath
	logic                            sat;
	logic [pkvt_pkg::COUNT_BITS-1:0] cnt_inc;
	logic                            last_entry;

	assign out_free   = !out_valid_q || result_ready;
	assign sat        = (vote_rd_q == pkvt_pkg::COUNT_MAX);
	assign cnt_inc    = vote_rd_q + 1'b1;
	assign last_entry = ((pkvt_pkg::LEN_W'(idx_q) + pkvt_pkg::LEN_W'(1)) == info_rd_q.len);
	assign clearing   = clr_q;

	always_comb begin
		state_d            = state_q;
		pop                = 1'b0;
		vote_re            = 1'b0;
		vote_raddr         = {head.cmd.key, head.cmd.rel};
		vote_we            = 1'b0;
		vote_waddr         = {cmd_q.key, cmd_q.rel};
		vote_wdata         = cnt_inc;
		info_re            = 1'b0;
		info_raddr         = head.cmd.key;
		info_we            = 1'b0;
		info_waddr         = cmd_q.key;
		info_wdata         = info_rd_q;
		leader_re          = 1'b0;
		leader_raddr       = {cmd_q.key, pkvt_pkg::REL_W'(0)};
		leader_we          = 1'b0;
		leader_waddr       = {cmd_q.key, pkvt_pkg::REL_W'(0)};
		leader_wdata       = cmd_q.rel;
		idx_load           = 1'b0;
		idx_d              = '0;
		out_load           = 1'b0;
		out_is_new_d       = 1'b0;
		out_leader_d       = '0;
		out_leader_valid_d = 1'b0;
		out_best_d         = info_rd_q.best;
		out_last_d         = 1'b1;

		if (clr_q) begin
			vote_we    = 1'b1;
			vote_waddr = clr_addr_q;
			vote_wdata = '0;
			info_we    = 1'b1;
			info_waddr = clr_addr_q[pkvt_pkg::KEY_W-1:0];
			info_wdata = '0;
		end

		unique case (state_q)
			pkvt_pkg::ST_IDLE: begin
				if (!clr_q && head.valid) begin
					pop     = 1'b1;
					vote_re = 1'b1;
					info_re = 1'b1;
					state_d = (head.cmd.op == pkvt_pkg::OP_ADD) ?
						pkvt_pkg::ST_ADD : pkvt_pkg::ST_QINFO;
				end
			end
			pkvt_pkg::ST_ADD: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_is_new_d = (vote_rd_q == '0);
					vote_we      = !sat;
					if (!sat && cnt_inc > info_rd_q.best) begin
						info_we         = 1'b1;
						info_wdata.best = cnt_inc;
						info_wdata.len  = pkvt_pkg::LEN_W'(1);
						leader_we       = 1'b1;
						out_best_d      = cnt_inc;
					end else if (!sat && cnt_inc == info_rd_q.best &&
							info_rd_q.len < pkvt_pkg::LEN_W'(pkvt_pkg::NUM_RELATIONS)) begin
						info_we        = 1'b1;
						info_wdata.len = info_rd_q.len + 1'b1;
						leader_we      = 1'b1;
						leader_waddr   = {cmd_q.key, info_rd_q.len[pkvt_pkg::REL_W-1:0]};
					end
					state_d = pkvt_pkg::ST_IDLE;
				end
			end
			pkvt_pkg::ST_QINFO: begin
				if (info_rd_q.len == '0) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d  = pkvt_pkg::ST_IDLE;
					end
				end else begin
					leader_re = 1'b1;
					idx_load  = 1'b1;
					idx_d     = '0;
					state_d   = pkvt_pkg::ST_QEMIT;
				end
			end
			pkvt_pkg::ST_QEMIT: begin
				if (out_free) begin
					out_load           = 1'b1;
					out_leader_d       = leader_rd_q;
					out_leader_valid_d = 1'b1;
					out_last_d         = last_entry;
					if (last_entry) begin
						state_d = pkvt_pkg::ST_IDLE;
					end else begin
						leader_re    = 1'b1;
						leader_raddr = {cmd_q.key, idx_q + 1'b1};
						idx_load     = 1'b1;
						idx_d        = idx_q + 1'b1;
					end
				end
			end
		endcase
	end

	// Memory ports, read data registered.
	always_ff @(posedge clk) begin
		if (vote_we)
			vote_mem[vote_waddr] <= vote_wdata;
		if (vote_re)
			vote_rd_q <= vote_mem[vote_raddr];
	end

	always_ff @(posedge clk) begin
		if (info_we)
			info_mem[info_waddr] <= info_wdata;
		if (info_re)
			info_rd_q <= info_mem[info_raddr];
	end

	always_ff @(posedge clk) begin
		if (leader_we)
			leader_mem[leader_waddr] <= leader_wdata;
		if (leader_re)
			leader_rd_q <= leader_mem[leader_raddr];
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= head.cmd;
		if (idx_load)
			idx_q <= idx_d;
		if (out_load) begin
			out_is_new_q       <= out_is_new_d;
			out_leader_q       <= out_leader_d;
			out_leader_valid_q <= out_leader_valid_d;
			out_best_q         <= out_best_d;
			out_last_q         <= out_last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pkvt_pkg::ST_IDLE;
			clr_q       <= 1'b1;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == pkvt_pkg::ADDR_W'(pkvt_pkg::VOTE_DEPTH - 1))
					clr_q <= 1'b0;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign is_new       = out_is_new_q;
	assign leader       = pkvt_pkg::LEADER_W'(out_leader_q);
	assign leader_valid = out_leader_valid_q;
	assign best_count   = pkvt_pkg::BEST_W'(out_best_q);
	assign last         = out_last_q;

	// No result may appear before the table sweep has finished.
	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !out_valid_q)
		else $error("result presented during table sweep");

	// The list walk never runs past the stored length.
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pkvt_pkg::ST_QEMIT) |->
			(pkvt_pkg::LEN_W'(idx_q) < info_rd_q.len))
		else $error("leader walk past list length");

	// A completed add leaves exactly one final result behind it.
	a_add_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pkvt_pkg::ST_ADD && out_free) |=>
			(out_valid_q && out_last_q && !out_leader_valid_q &&
			state_q == pkvt_pkg::ST_IDLE))
		else $error("add did not produce a single final result");

	// Commands are only taken off the queue by an idle sequencer.
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == pkvt_pkg::ST_IDLE && head.valid && !clr_q))
		else $error("command taken while busy");

endmodule

// ===== src/per_key_vote_mode_tracker_top.sv =====
// Top level of the per-key vote mode tracker: front end, command queue, back end.
// Depends on pkvt_pkg, pkvt_front, pkvt_queue and pkvt_back.
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   ------------------------------------------
//   item      item_valid / item_ready      func, key, relation
//   result    result_valid / result_ready  is_new, leader, leader_valid, best_count, last
//
// An add reads the count and the key's summary word, then, once the result register is
// free, updates the count, summary and leader list and loads the result. A query reads
// the summary; an empty list gives a single result with no leader, else each entry is
// read from the leader memory, every later one in the cycle its predecessor is loaded
// into the result register. After reset the count and summary memories are swept to
// zero, one entry a cycle; item_ready stays low until the sweep ends.
// Either side may stall: a two-entry command queue decouples input transfers from the
// back end, and the result register holds a result until its transfer completes.

module per_key_vote_mode_tracker_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [pkvt_pkg::FUNC_W-1:0]   func,
	input  logic [pkvt_pkg::KEY_IN_W-1:0] key,
	input  logic [pkvt_pkg::REL_IN_W-1:0] relation,
	output logic                          result_valid,
	input  logic                          result_ready,
	output logic                          is_new,
	output logic [pkvt_pkg::LEADER_W-1:0] leader,
	output logic                          leader_valid,
	output logic [pkvt_pkg::BEST_W-1:0]   best_count,
	output logic                          last
);

	pkvt_pkg::q_push_t push;
	pkvt_pkg::q_head_t head;
	logic              q_full;
	logic              pop;
	logic              clearing;

	// Decode and id wrapping; refuses transfers while the queue is full or the
	// memories are still being swept.
	pkvt_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.func       (func),
		.key        (key),
		.relation   (relation),
		.clearing   (clearing),
		.q_full     (q_full),
		.push       (push)
	);

	pkvt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// Sequencer, memories and result register.
	pkvt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.is_new       (is_new),
		.leader       (leader),
		.leader_valid (leader_valid),
		.best_count   (best_count),
		.last         (last)
	);

endmodule

// ===== test/vote_tally_checker.sv =====
`timescale 1ns / 1ps
// Checker for the per-key vote mode tracker: watches both channels, keeps its own
// vote tallies and compares every result transfer. Depends on pkvt_pkg only.

module vote_tally_checker
	import pkvt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_ready,
	input  op_t                   func,
	input  logic [KEY_IN_W-1:0]   key,
	input  logic [REL_IN_W-1:0]   relation,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  logic                  is_new,
	input  logic [LEADER_W-1:0]   leader,
	input  logic                  leader_valid,
	input  logic [BEST_W-1:0]     best_count,
	input  logic                  last,
	output int                    mismatch_count,
	output int                    awaiting,
	output int                    results_seen,
	output int                    adds_seen,
	output int                    queries_seen,
	output int                    longest_list,
	output int                    saturated_adds
);

	typedef struct packed {
		logic                is_new;
		logic [LEADER_W-1:0] leader;
		logic                leader_valid;
		logic [BEST_W-1:0]   best_count;
		logic                last;
	} tally_t;

	logic [COUNT_BITS-1:0] vote_cnt [VOTE_DEPTH];
	logic [COUNT_BITS-1:0] key_best [NUM_KEYS];
	logic [REL_W-1:0]      key_leaders [NUM_KEYS][NUM_RELATIONS];
	logic [LEN_W-1:0]      key_len [NUM_KEYS];
	tally_t                awaited_results [$];

	// Applies one accepted item to the tallies and queues the results it must produce.
	task automatic tally_item(input op_t op, input logic [KEY_IN_W-1:0] k,
			input logic [REL_IN_W-1:0] r);
		int                    kk;
		int                    rr;
		int                    slot;
		int                    len;
		logic [COUNT_BITS-1:0] cnt;
		tally_t                t;
		kk   = int'(k) % NUM_KEYS;
		rr   = int'(r) % NUM_RELATIONS;
		slot = kk * NUM_RELATIONS + rr;
		t    = '0;
		if (op == OP_ADD) begin
			adds_seen++;
			cnt = vote_cnt[slot];
			if (cnt == COUNT_MAX) begin
				saturated_adds++;
			end else begin
				cnt++;
				vote_cnt[slot] = cnt;
				t.is_new = (cnt == 1);
				if (cnt > key_best[kk]) begin
					key_best[kk]       = cnt;
					key_leaders[kk][0] = REL_W'(rr);
					key_len[kk]        = LEN_W'(1);
				end else if (cnt == key_best[kk] &&
						key_len[kk] < LEN_W'(NUM_RELATIONS)) begin
					key_leaders[kk][key_len[kk][REL_W-1:0]] = REL_W'(rr);
					key_len[kk] = key_len[kk] + LEN_W'(1);
				end
			end
			t.best_count = BEST_W'(key_best[kk]);
			t.last       = 1'b1;
			awaited_results.push_back(t);
		end else begin
			queries_seen++;
			t.best_count = BEST_W'(key_best[kk]);
			len          = int'(key_len[kk]);
			if (len == 0) begin
				t.last = 1'b1;
				awaited_results.push_back(t);
			end else begin
				for (int i = 0; i < len; i++) begin
					t.leader       = key_leaders[kk][i];
					t.leader_valid = 1'b1;
					t.last         = (i == len - 1);
					awaited_results.push_back(t);
				end
				if (len > longest_list)
					longest_list = len;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		tally_t want;
		tally_t got;
		if (!arst_n) begin
			for (int i = 0; i < VOTE_DEPTH; i++)
				vote_cnt[i] = '0;
			for (int i = 0; i < NUM_KEYS; i++) begin
				key_best[i] = '0;
				key_len[i]  = '0;
			end
			awaited_results.delete();
			mismatch_count = 0;
			results_seen   = 0;
			adds_seen      = 0;
			queries_seen   = 0;
			longest_list   = 0;
			saturated_adds = 0;
			awaiting      <= 0;
		end else begin
			// Results are checked before the item of the same edge is applied, since
			// a result can never belong to an item accepted at the same edge.
			if (result_valid && result_ready) begin
				results_seen++;
				got = '{is_new, leader, leader_valid, best_count, last};
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: result transfer with none awaited: ",
							"is_new=%0d leader=%0d leader_valid=%0d best_count=%0d ",
							"last=%0d"},
							$realtime, got.is_new, got.leader, got.leader_valid,
							got.best_count, got.last);
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%0t: result mismatch: expected is_new=%0d ",
								"leader=%0d leader_valid=%0d best_count=%0d last=%0d, ",
								"got is_new=%0d leader=%0d leader_valid=%0d ",
								"best_count=%0d last=%0d"},
								$realtime, want.is_new, want.leader,
								want.leader_valid, want.best_count, want.last,
								got.is_new, got.leader, got.leader_valid,
								got.best_count, got.last);
					end
				end
			end
			if (item_valid && item_ready)
				tally_item(func, key, relation);
			awaiting <= awaited_results.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the vote mode tracker testbench: clock, reset, stimulus and the verdict.
// Depends on pkvt_pkg, per_key_vote_mode_tracker_top and vote_tally_checker.

module testbench;
	import pkvt_pkg::*;

	// The worst case is dominated by the clearing sweep after reset, about 210 items,
	// some queries of up to 64 leaders and a receiver that can stall for long
	// stretches. This limit is many times the slowest correct run.
	localparam int LIMIT        = 300000;
	localparam int RANDOM_ITEMS = 125;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	op_t                   func         = OP_ADD;
	logic [KEY_IN_W-1:0]   key          = '0;
	logic [REL_IN_W-1:0]   relation     = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic                  is_new;
	logic [LEADER_W-1:0]   leader;
	logic                  leader_valid;
	logic [BEST_W-1:0]     best_count;
	logic                  last;

	int mismatch_count;
	int awaiting;
	int results_seen;
	int adds_seen;
	int queries_seen;
	int longest_list;
	int saturated_adds;

	int cycle_count = 0;
	int burst_left  = 0;
	int stall_mode  = 0;
	int mode_left   = 0;

	per_key_vote_mode_tracker_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.func         (func),
		.key          (key),
		.relation     (relation),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.is_new       (is_new),
		.leader       (leader),
		.leader_valid (leader_valid),
		.best_count   (best_count),
		.last         (last)
	);

	vote_tally_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.func           (func),
		.key            (key),
		.relation       (relation),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.is_new         (is_new),
		.leader         (leader),
		.leader_valid   (leader_valid),
		.best_count     (best_count),
		.last           (last),
		.mismatch_count (mismatch_count),
		.awaiting       (awaiting),
		.results_seen   (results_seen),
		.adds_seen      (adds_seen),
		.queries_seen   (queries_seen),
		.longest_list   (longest_list),
		.saturated_adds (saturated_adds)
	);

	always #6 clk = ~clk;

	// Watchdog: a run that hangs, or that leaves results owed, ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("Watchdog expired after %0d cycles with %0d results still owed.",
				cycle_count, awaiting);
			$display("Test completed with failures");
			$finish;
		end
	end

	// The receiver switches behaviour at random: always ready, a coin toss, mostly
	// stalled, or a fixed pattern that drops ready on cycle counts divisible by five.
	// This places stalls on every phase of a query's emission as well as on adds.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_left  <= $urandom_range(20, 120);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: begin
				result_ready <= 1'b1;
			end
			1: begin
				result_ready <= 1'($urandom_range(0, 1));
			end
			2: begin
				result_ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				result_ready <= (cycle_count % 5 != 0);
			end
		endcase
	end

	// Offers one item; returns just after its transfer completes, or after the gap below.
	// Valid stays high across a burst; when the burst runs out it drops for a random gap
	// and a new burst length is drawn, occasionally a long one with no idling at all.
	task automatic send_item(input op_t op, input logic [KEY_IN_W-1:0] k,
			input logic [REL_IN_W-1:0] r);
		int gap;
		item_valid <= 1'b1;
		func       <= op;
		key        <= k;
		relation   <= r;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
				: $urandom_range(1, 4);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
		end
	endtask

	initial begin : stimulus
		logic [KEY_IN_W-1:0] hot_keys [4];
		logic [REL_IN_W-1:0] hot_rels [6];
		logic [REL_IN_W-1:0] first_rel;
		logic [KEY_IN_W-1:0] k;
		logic [REL_IN_W-1:0] r;
		op_t                 op;
		int                  step;
		int                  offset;

		// Reset is held from the start and released at a rising edge. The block then
		// clears its memories and keeps item_ready low; send_item simply waits.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Queries of untouched keys must give the single empty-list
		// result with best count zero.
		send_item(OP_QUERY, 6'd0, 6'd0);
		send_item(OP_QUERY, 6'd63, 6'd63);
		// First votes on key 0: the first sets the list, the next two tie and append.
		send_item(OP_ADD, 6'd0, 6'd0);
		send_item(OP_ADD, 6'd0, 6'd63);
		send_item(OP_ADD, 6'd0, 6'd21);
		send_item(OP_QUERY, 6'd0, 6'd42);
		// A second vote beats the best and resets the list; later ones tie with it.
		send_item(OP_ADD, 6'd0, 6'd63);
		send_item(OP_ADD, 6'd0, 6'd0);
		send_item(OP_ADD, 6'd0, 6'd21);
		// A vote below the best leaves the list alone but is still a first vote.
		send_item(OP_ADD, 6'd0, 6'd42);
		// The relation field is ignored on a query.
		send_item(OP_QUERY, 6'd0, 6'd63);
		send_item(OP_ADD, 6'd63, 6'd63);
		send_item(OP_ADD, 6'd63, 6'd0);
		send_item(OP_ADD, 6'd42, 6'd42);
		send_item(OP_ADD, 6'd21, 6'd21);
		send_item(OP_QUERY, 6'd63, 6'd0);
		send_item(OP_QUERY, 6'd42, 6'd0);
		send_item(OP_QUERY, 6'd21, 6'd0);

		// Every relation of one key ties at one vote, in a random order, so the query
		// returns the longest possible list. One more vote then shrinks it to one.
		step      = 2 * $urandom_range(0, 31) + 1;
		offset    = $urandom_range(0, 63);
		first_rel = REL_IN_W'(offset);
		for (int i = 0; i < NUM_RELATIONS; i++)
			send_item(OP_ADD, 6'd37, REL_IN_W'(i * step + offset));
		send_item(OP_QUERY, 6'd37, 6'd0);
		send_item(OP_ADD, 6'd37, first_rel);
		send_item(OP_QUERY, 6'd37, 6'd0);

		// Random part. Most votes land on a few keys and relations so that counts grow
		// and ties keep forming; the rest spread over the whole range of both fields.
		for (int i = 0; i < 4; i++)
			hot_keys[i] = KEY_IN_W'($urandom);
		for (int i = 0; i < 6; i++)
			hot_rels[i] = REL_IN_W'($urandom);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			op = ($urandom_range(0, 3) == 0) ? OP_QUERY : OP_ADD;
			k  = ($urandom_range(0, 4) != 0) ? hot_keys[$urandom_range(0, 3)]
				: KEY_IN_W'($urandom);
			r  = ($urandom_range(0, 4) != 0) ? hot_rels[$urandom_range(0, 5)]
				: REL_IN_W'($urandom);
			send_item(op, k, r);
		end
		item_valid <= 1'b0;

		// The owed count is a registered copy, so look only after the next edge.
		// Then allow a quiet stretch in which any spurious result would still show up.
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		$display("Run covered %0d adds (%0d at a saturated count) and %0d queries.",
			adds_seen, saturated_adds, queries_seen);
		$display("%0d result transfers checked; longest leader list seen: %0d entries.",
			results_seen, longest_list);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d failing result transfers.", mismatch_count);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/pkvt_pkg.sv
src/pkvt_front.sv
src/pkvt_queue.sv
src/pkvt_back.sv
src/per_key_vote_mode_tracker_top.sv
test/vote_tally_checker.sv
test/testbench.sv
